>>> design/ppq_pkg.sv
`default_nettype none

package ppq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_WIDTH_DEF    = 8;
   localparam int NUM_QUEUES      = 4;
   localparam int QSEL_W          = 2;
   localparam int PID_W           = 8;
   localparam int PRIO_W          = 4;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_FIND   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_DUPLICATE = 2'd3
   } status_type;

   // per-queue command for one item
   typedef struct packed {
      logic capture;   // latch compare flags in every cell
      logic insert;    // open a gap and load the new entry
      logic remove;    // close the gap at the matching entry
      logic clear;     // empty the queue
   } ctrl_type;

   // rippled along the row: match seen so far and its priority
   typedef struct packed {
      logic              seen;
      logic [PRIO_W-1:0] prio;
   } chain_type;

   typedef struct packed {
      logic              found;
      logic              full;
      logic [PRIO_W-1:0] prio;
   } qstat_type;

endpackage

`default_nettype wire

>>> design/ppq_cell.sv
`default_nettype none

module ppq_cell #(
   parameter int ID_WIDTH = ppq_pkg::ID_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire ppq_pkg::ctrl_type           ctrl,
   input  wire logic                        occupied,
   input  wire logic [ID_WIDTH-1:0]         cmp_id,
   input  wire logic [ppq_pkg::PRIO_W-1:0]  cmp_prio,
   input  wire logic                        le_left,
   input  wire logic [ID_WIDTH-1:0]         left_id,
   input  wire logic [ppq_pkg::PRIO_W-1:0]  left_prio,
   input  wire logic [ID_WIDTH-1:0]         right_id,
   input  wire logic [ppq_pkg::PRIO_W-1:0]  right_prio,
   input  wire ppq_pkg::chain_type          chain_in,
   output ppq_pkg::chain_type               chain_out,
   output logic                             le_out,
   output logic [ID_WIDTH-1:0]              id_out,
   output logic [ppq_pkg::PRIO_W-1:0]       prio_out
);

   logic [ID_WIDTH-1:0]        id_ff, id_in;
   logic [ppq_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic                       match_ff, match_in;
   logic                       le_ff, le_in;

   // flags are taken once, on the accept edge
   always_comb begin
      match_in = match_ff;
      le_in    = le_ff;
      if (ctrl.capture) begin
         match_in = occupied && (id_ff == cmp_id);
         le_in    = occupied && (prio_ff <= cmp_prio);
      end
   end

   // insert: cells at or below the new priority hold, the first one above
   // loads, the rest take from the left. remove: from the match on, take
   // from the right.
   always_comb begin
      id_in   = id_ff;
      prio_in = prio_ff;
      if (ctrl.insert) begin
         if (!le_ff) begin
            if (le_left) begin
               id_in   = cmp_id;
               prio_in = cmp_prio;
            end else begin
               id_in   = left_id;
               prio_in = left_prio;
            end
         end
      end else if (ctrl.remove) begin
         if (chain_in.seen || match_ff) begin
            id_in   = right_id;
            prio_in = right_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      prio_ff  <= prio_in;
      match_ff <= match_in;
      le_ff    <= le_in;
   end

   assign chain_out.seen = chain_in.seen | match_ff;
   assign chain_out.prio = chain_in.prio | (match_ff ? prio_ff : '0);
   assign le_out         = le_ff;
   assign id_out         = id_ff;
   assign prio_out       = prio_ff;

endmodule

`default_nettype wire

>>> design/ppq_queue.sv
`default_nettype none

module ppq_queue #(
   parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = ppq_pkg::ID_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ppq_pkg::ctrl_type           ctrl,
   input  wire logic [ID_WIDTH-1:0]         cmp_id,
   input  wire logic [ppq_pkg::PRIO_W-1:0]  cmp_prio,
   output ppq_pkg::qstat_type               stat
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;

   logic [ID_WIDTH-1:0]        ids   [QUEUE_DEPTH];
   logic [ppq_pkg::PRIO_W-1:0] prios [QUEUE_DEPTH];
   logic                       les   [QUEUE_DEPTH];
   ppq_pkg::chain_type         chain [QUEUE_DEPTH+1];

   assign chain[0] = '{seen: 1'b0, prio: '0};

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                       occ;
      logic                       le_l;
      logic [ID_WIDTH-1:0]        l_id, r_id;
      logic [ppq_pkg::PRIO_W-1:0] l_pr, r_pr;

      assign occ = CNT_W'(i) < count_ff;

      if (i == 0) begin : g_first
         assign le_l = 1'b1;
         assign l_id = cmp_id;
         assign l_pr = cmp_prio;
      end else begin : g_mid
         assign le_l = les[i-1];
         assign l_id = ids[i-1];
         assign l_pr = prios[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign r_id = ids[i];
         assign r_pr = prios[i];
      end else begin : g_inner
         assign r_id = ids[i+1];
         assign r_pr = prios[i+1];
      end

      ppq_cell #(
         .ID_WIDTH (ID_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occ),
         .cmp_id     (cmp_id),
         .cmp_prio   (cmp_prio),
         .le_left    (le_l),
         .left_id    (l_id),
         .left_prio  (l_pr),
         .right_id   (r_id),
         .right_prio (r_pr),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .le_out     (les[i]),
         .id_out     (ids[i]),
         .prio_out   (prios[i])
      );
   end

   assign stat.found = chain[QUEUE_DEPTH].seen;
   assign stat.prio  = chain[QUEUE_DEPTH].prio;
   assign stat.full  = count_ff == CNT_W'(QUEUE_DEPTH);

   always_comb begin
      priority if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove && stat.found) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

endmodule

`default_nettype wire

>>> design/process_priority_queues_core.sv
`default_nettype none

// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: mode; tdata: queue_select, process_id, priority_req
// rsp      out  rsp_tvalid/rsp_tready  tdata: status, found_queue, found_priority
//
// Each item takes two steps: the accept edge latches the id/priority compares in
// every cell, then the apply edge applies the item to the queues and loads the result.
// The apply step waits while an earlier result is still held on rsp.
// Reset (synchronous) empties all four queues at once through the counts;
// cell contents are left as they are, there is no clearing pass.
// Entry fields past a queue's count are never visible at the outputs.

module process_priority_queues_core #(
   parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = ppq_pkg::ID_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // queue_select[1:0], process_id[9:2],
                                         // priority_req[13:10], zero[15:14]
   input  wire logic [1:0]  req_tuser,   // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // status[1:0], found_queue[3:2],
                                         // found_priority[7:4]
);

   localparam int NQ = ppq_pkg::NUM_QUEUES;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // request fields, straight off the port
   logic [ppq_pkg::QSEL_W-1:0] in_qsel;
   logic [ppq_pkg::PID_W-1:0]  in_pid;
   logic [ppq_pkg::PRIO_W-1:0] in_prio;
   logic [ID_WIDTH-1:0]        in_id;

   assign in_qsel = req_tdata[1:0];
   assign in_pid  = req_tdata[9:2];
   assign in_prio = req_tdata[13:10];

   // only the low ID_WIDTH bits of the id take part
   if (ID_WIDTH >= ppq_pkg::PID_W) begin : g_id_wide
      assign in_id = ID_WIDTH'(in_pid);
   end else begin : g_id_narrow
      assign in_id = in_pid[ID_WIDTH-1:0];
   end

   // latched request
   ppq_pkg::mode_type          mode_ff, mode_in;
   logic [ppq_pkg::QSEL_W-1:0] qsel_ff, qsel_in;
   logic [ID_WIDTH-1:0]        id_ff, id_in;
   logic [ppq_pkg::PRIO_W-1:0] prio_ff, prio_in;

   logic req_fire;
   logic apply_fire;

   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign apply_fire = (state_ff == ST_APPLY) && (!rsp_tvalid || rsp_tready);

   // compare operand: port value at accept, latched value while applying
   logic [ID_WIDTH-1:0]        cmp_id;
   logic [ppq_pkg::PRIO_W-1:0] cmp_prio;

   assign cmp_id   = req_fire ? in_id : id_ff;
   assign cmp_prio = req_fire ? in_prio : prio_ff;

   ppq_pkg::ctrl_type  ctrl [NQ];
   ppq_pkg::qstat_type stat [NQ];
   logic [NQ-1:0]      found_vec;
   logic               any_found;

   for (genvar q = 0; q < NQ; q++) begin : g_queue
      assign found_vec[q] = stat[q].found;
   end
   assign any_found = |found_vec;

   // duplicate check spans all queues; full check only the selected one
   for (genvar q = 0; q < NQ; q++) begin : g_row
      logic sel;
      assign sel = qsel_ff == ppq_pkg::QSEL_W'(q);

      assign ctrl[q].capture = req_fire;
      assign ctrl[q].insert  = apply_fire && (mode_ff == ppq_pkg::MODE_INSERT) && sel
                               && !any_found && !stat[q].full;
      assign ctrl[q].remove  = apply_fire && (mode_ff == ppq_pkg::MODE_REMOVE) && sel;
      assign ctrl[q].clear   = apply_fire && (mode_ff == ppq_pkg::MODE_CLEAR);

      ppq_queue #(
         .QUEUE_DEPTH (QUEUE_DEPTH),
         .ID_WIDTH    (ID_WIDTH)
      ) u_queue (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl[q]),
         .cmp_id   (cmp_id),
         .cmp_prio (cmp_prio),
         .stat     (stat[q])
      );
   end

   // result of the applied item
   ppq_pkg::status_type        res_status;
   logic [ppq_pkg::QSEL_W-1:0] res_fq;
   logic [ppq_pkg::PRIO_W-1:0] res_fp;
   logic [ppq_pkg::QSEL_W-1:0] find_q;
   logic [ppq_pkg::PRIO_W-1:0] find_p;

   // lowest-numbered queue wins, matching the search order 0..3
   always_comb begin
      find_q = '0;
      find_p = '0;
      for (int q = NQ - 1; q >= 0; q--) begin
         if (stat[q].found) begin
            find_q = ppq_pkg::QSEL_W'(q);
            find_p = stat[q].prio;
         end
      end
   end

   always_comb begin
      res_status = ppq_pkg::STATUS_OK;
      res_fq     = '0;
      res_fp     = '0;
      unique case (mode_ff)
         ppq_pkg::MODE_INSERT: begin
            if (any_found) begin
               res_status = ppq_pkg::STATUS_DUPLICATE;
            end else if (stat[qsel_ff].full) begin
               res_status = ppq_pkg::STATUS_FULL;
            end
         end
         ppq_pkg::MODE_REMOVE: begin
            if (!stat[qsel_ff].found) begin
               res_status = ppq_pkg::STATUS_NOT_FOUND;
            end
         end
         ppq_pkg::MODE_FIND: begin
            if (any_found) begin
               res_fq = find_q;
               res_fp = find_p;
            end else begin
               res_status = ppq_pkg::STATUS_NOT_FOUND;
            end
         end
         ppq_pkg::MODE_CLEAR: begin
            res_status = ppq_pkg::STATUS_OK;
         end
         default: begin
            res_status = ppq_pkg::STATUS_OK;
         end
      endcase
   end

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (apply_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res_fp, res_fq, res_status};
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      qsel_in  = qsel_ff;
      id_in    = id_ff;
      prio_in  = prio_ff;
      state_in = state_ff;
      if (req_fire) begin
         mode_in  = ppq_pkg::mode_type'(req_tuser);
         qsel_in  = in_qsel;
         id_in    = in_id;
         prio_in  = in_prio;
         state_in = ST_APPLY;
      end else if (apply_fire) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      qsel_ff     <= qsel_in;
      id_ff       <= id_in;
      prio_ff     <= prio_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_accept_to_apply: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_APPLY)
      else $error("accepted item did not move to apply");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(apply_fire))
      else $error("result appeared without an apply step");

   a_id_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> $countones(found_vec) <= 1)
      else $error("id present in more than one queue");

   a_apply_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_APPLY) && !apply_fire) |=> state_ff == ST_APPLY)
      else $error("apply step left while result stalled");

endmodule

`default_nettype wire
